>>> rtl/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants for the complex Gauss-Seidel solver unit.
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int MAX_ORDER = 16;
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] KIND_MAT   = 2'd0;
    localparam logic [1:0] KIND_GUESS = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    localparam logic [1:0] REG_ORDER    = 2'd0;
    localparam logic [1:0] REG_MAX_ITER = 2'd1;
    localparam logic [1:0] REG_TOL      = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          row;
        logic [4:0]          col;
        logic signed [31:0]  re_value;
        logic signed [31:0]  im_value;
    } in_t;

    typedef struct packed {
        logic [3:0]          index;
        logic signed [31:0]  re_result;
        logic signed [31:0]  im_result;
        logic                converged;
        logic                last;
    } out_t;

    typedef enum logic [1:0] {
        TGT_RR,
        TGT_RI,
        TGT_ACC
    } tgt_t;

    typedef enum logic [1:0] {
        SHF_FLOOR,
        SHF_0,
        SHF_32,
        SHF_64
    } shf_t;

    typedef struct packed {
        logic en;
        tgt_t tgt;
        shf_t shf;
        logic sub;
    } acc_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_TST,
        ST_TOL,
        ST_TOL_W,
        ST_ROW_DG,
        ST_ROW_RHS,
        ST_ROW_INIT,
        ST_J_RD,
        ST_J_M0,
        ST_J_M1,
        ST_J_M2,
        ST_J_M3,
        ST_DEN0,
        ST_DEN1,
        ST_DEN2,
        ST_LHS,
        ST_LHS_W,
        ST_RHS,
        ST_RHS_W,
        ST_CMP,
        ST_UPD,
        ST_UPD_W,
        ST_DSET,
        ST_DIV,
        ST_DEND,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

endpackage

>>> rtl/complex_gauss_seidel_solver_unit.sv
// ----------------------------------------------------------------------------
// complex_gauss_seidel_solver_unit
// Complex Gauss-Seidel solver over a stored augmented matrix, Q16.16 data.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Kinds 0 and 1 write
//   one matrix or initial-guess element; busy stays low. Kind 2 starts a
//   solve: busy rises the next cycle and stays high until the solution has
//   been emitted. Results appear on result, each marked by result_valid for
//   one cycle; last flags the final element.
//   The receiver cannot stall; results are simply presented.
//   Solve time is set by one shared 33x33 multiplier with a 128-bit
//   accumulator and a 1-bit-per-cycle restoring divider. A solve runs a
//   diagonal check, then per row per sweep two divisions, then the output.
//   Configuration (order, max_iterations, tolerance) is to be written by the
//   user over the APB port at byte addresses 0, 4, 8 while idle; the block
//   itself does not enforce this. Reset returns the registers to 1, 100, 66
//   and the controller to idle; matrix and guess contents are undefined
//   until written.
// ----------------------------------------------------------------------------
module complex_gauss_seidel_solver_unit #(
    parameter int MAX_ORDER = cgs_pkg::MAX_ORDER,
    parameter int FRAC_BITS = cgs_pkg::FRAC_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cgs_pkg::in_t   item,
    output logic           result_valid,
    output cgs_pkg::out_t  result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int NCOLS = MAX_ORDER + 1;
    localparam int DEPTH = MAX_ORDER * NCOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam logic [127:0] BIAS = (128'd1 << (2 * FRAC_BITS)) - 128'd1;

    // configuration
    logic [4:0]  order_reg;
    logic [15:0] maxit_reg;
    logic [30:0] tol_reg;

    // control
    cgs_pkg::state_t   state_reg, state_next;
    logic [NW-1:0]     i_reg, j_reg, n_reg, n_clamp;
    logic [2:0]        k_reg;
    logic [6:0]        cnt_reg;
    logic              upd_im_reg, again_reg, fail_reg, ok_reg, rv_reg;
    logic [16:0]       sweep_reg;
    cgs_pkg::acc_cmd_t cmd, cmd_reg;

    // datapath
    logic [63:0]         rr_reg, ri_reg, den_reg, tol2_reg, rem_reg;
    logic [127:0]        acc_reg, lhs_reg, num_reg;
    logic [31:0]         dr_reg, di_reg, newre_reg;
    logic signed [65:0]  prod_reg;
    logic [32:0]         q_reg;
    logic                sticky_reg, neg_reg;
    cgs_pkg::out_t       result_reg;

    // memories
    logic [63:0]   mat_mem [DEPTH];
    logic [63:0]   gs_mem [MAX_ORDER];
    logic [63:0]   mat_q, gs_q;
    logic          mat_we, mat_re, gs_we, gs_re;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [GW-1:0] gs_waddr, gs_raddr;
    logic [63:0]   gs_wdata;

    logic               accept, ld_mat_ok, ld_gs_ok, diag_zero, row_last, more, div_ge;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next, fl;
    logic [127:0]       base, addend, sum, acc_mag;
    logic [16:0]        sc_inc;
    logic [64:0]        rem_sh, rem_dif;
    logic               q_big;
    logic [32:0]        qm;
    logic [31:0]        z, sat;
    logic [34:0]        zx, qx, dif;
    logic [31:0]        cre, cim, zre, zim;
    logic [63:0]        lx;

    function automatic logic [AW-1:0] maddr(input logic [NW-1:0] r, input logic [NW-1:0] c);
        logic [AW:0] t;
        t = (AW+1)'(r) * (AW+1)'(NCOLS) + (AW+1)'(c);
        maddr = t[AW-1:0];
    endfunction

    function automatic logic [32:0] lo33(input logic [63:0] x);
        lo33 = {1'b0, x[31:0]};
    endfunction

    function automatic logic [32:0] shi33(input logic [63:0] x);
        shi33 = {x[63], x[63:32]};
    endfunction

    function automatic logic [32:0] uhi33(input logic [63:0] x);
        uhi33 = {1'b0, x[63:32]};
    endfunction

    function automatic logic [32:0] s33(input logic [31:0] x);
        s33 = {x[31], x};
    endfunction

    function automatic logic [63:0] sx64(input logic [31:0] x);
        sx64 = {{32{x[31]}}, x};
    endfunction

    assign accept    = start && (state_reg == cgs_pkg::ST_IDLE);
    assign ld_mat_ok = (32'(item.row) < 32'(MAX_ORDER)) && (32'(item.col) < 32'(NCOLS));
    assign ld_gs_ok  = 32'(item.row) < 32'(MAX_ORDER);
    assign diag_zero = (mat_q == '0);
    assign row_last  = (NW'(i_reg + 1'b1) == n_reg);
    assign sc_inc    = sweep_reg + 17'd1;
    assign more      = again_reg && (sc_inc <= {1'b0, maxit_reg});
    assign cre = mat_q[63:32];
    assign cim = mat_q[31:0];
    assign zre = gs_q[63:32];
    assign zim = gs_q[31:0];

    always_comb
    begin
        if (order_reg == '0)
            n_clamp = NW'(1);
        else if (32'(order_reg) > 32'(MAX_ORDER))
            n_clamp = NW'(MAX_ORDER);
        else
            n_clamp = NW'(order_reg);
    end

    // ---------------- APB ----------------
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            cgs_pkg::REG_ORDER:    prdata = 32'(order_reg);
            cgs_pkg::REG_MAX_ITER: prdata = 32'(maxit_reg);
            cgs_pkg::REG_TOL:      prdata = 32'(tol_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 5'd1;
            maxit_reg <= 16'd100;
            tol_reg   <= 31'd66;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                cgs_pkg::REG_ORDER:    order_reg <= pwdata[4:0];
                cgs_pkg::REG_MAX_ITER: maxit_reg <= pwdata[15:0];
                cgs_pkg::REG_TOL:      tol_reg   <= pwdata[30:0];
                default:               ;
            endcase
        end
    end

    // ---------------- memories ----------------
    always_comb
    begin
        mat_we    = accept && (item.kind == cgs_pkg::KIND_MAT) && ld_mat_ok;
        mat_waddr = maddr(NW'(item.row), NW'(item.col));
        if (state_reg == cgs_pkg::ST_DEND)
        begin
            gs_we    = upd_im_reg;
            gs_waddr = i_reg[GW-1:0];
            gs_wdata = {newre_reg, sat};
        end
        else
        begin
            gs_we    = accept && (item.kind == cgs_pkg::KIND_GUESS) && ld_gs_ok;
            gs_waddr = GW'(item.row);
            gs_wdata = {item.re_value, item.im_value};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_waddr] <= {item.re_value, item.im_value};
        if (mat_re)
            mat_q <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gs_we)
            gs_mem[gs_waddr] <= gs_wdata;
        if (gs_re)
            gs_q <= gs_mem[gs_raddr];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cgs_pkg::ST_IDLE:
                if (accept && item.kind == cgs_pkg::KIND_SOLVE)
                    state_next = cgs_pkg::ST_CHK_RD;
            cgs_pkg::ST_CHK_RD:   state_next = cgs_pkg::ST_CHK_TST;
            cgs_pkg::ST_CHK_TST:
                if (!row_last)
                    state_next = cgs_pkg::ST_CHK_RD;
                else if (fail_reg || diag_zero)
                    state_next = cgs_pkg::ST_OUT_RD;
                else
                    state_next = cgs_pkg::ST_TOL;
            cgs_pkg::ST_TOL:      state_next = cgs_pkg::ST_TOL_W;
            cgs_pkg::ST_TOL_W:    state_next = cgs_pkg::ST_ROW_DG;
            cgs_pkg::ST_ROW_DG:   state_next = cgs_pkg::ST_ROW_RHS;
            cgs_pkg::ST_ROW_RHS:  state_next = cgs_pkg::ST_ROW_INIT;
            cgs_pkg::ST_ROW_INIT: state_next = cgs_pkg::ST_J_RD;
            cgs_pkg::ST_J_RD:     state_next = cgs_pkg::ST_J_M0;
            cgs_pkg::ST_J_M0:     state_next = cgs_pkg::ST_J_M1;
            cgs_pkg::ST_J_M1:     state_next = cgs_pkg::ST_J_M2;
            cgs_pkg::ST_J_M2:     state_next = cgs_pkg::ST_J_M3;
            cgs_pkg::ST_J_M3:
                state_next = (NW'(j_reg + 1'b1) == n_reg) ? cgs_pkg::ST_DEN0
                                                           : cgs_pkg::ST_J_RD;
            cgs_pkg::ST_DEN0:     state_next = cgs_pkg::ST_DEN1;
            cgs_pkg::ST_DEN1:     state_next = cgs_pkg::ST_DEN2;
            cgs_pkg::ST_DEN2:     state_next = cgs_pkg::ST_LHS;
            cgs_pkg::ST_LHS:
                if (k_reg == 3'd7)
                    state_next = cgs_pkg::ST_LHS_W;
            cgs_pkg::ST_LHS_W:    state_next = cgs_pkg::ST_RHS;
            cgs_pkg::ST_RHS:
                if (k_reg == 3'd3)
                    state_next = cgs_pkg::ST_RHS_W;
            cgs_pkg::ST_RHS_W:    state_next = cgs_pkg::ST_CMP;
            cgs_pkg::ST_CMP:      state_next = cgs_pkg::ST_UPD;
            cgs_pkg::ST_UPD:
                if (k_reg == 3'd3)
                    state_next = cgs_pkg::ST_UPD_W;
            cgs_pkg::ST_UPD_W:    state_next = cgs_pkg::ST_DSET;
            cgs_pkg::ST_DSET:     state_next = cgs_pkg::ST_DIV;
            cgs_pkg::ST_DIV:
                if (cnt_reg == 7'd127)
                    state_next = cgs_pkg::ST_DEND;
            cgs_pkg::ST_DEND:
                if (!upd_im_reg)
                    state_next = cgs_pkg::ST_UPD;
                else if (row_last && !more)
                    state_next = cgs_pkg::ST_OUT_RD;
                else
                    state_next = cgs_pkg::ST_ROW_DG;
            cgs_pkg::ST_OUT_RD:   state_next = cgs_pkg::ST_OUT_EMIT;
            cgs_pkg::ST_OUT_EMIT:
                state_next = row_last ? cgs_pkg::ST_IDLE : cgs_pkg::ST_OUT_RD;
            default:              state_next = cgs_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        mat_re    = 1'b0;
        mat_raddr = maddr(i_reg, i_reg);
        gs_re     = 1'b0;
        gs_raddr  = i_reg[GW-1:0];
        mul_a     = '0;
        mul_b     = '0;
        cmd       = '0;
        lx        = k_reg[2] ? ri_reg : rr_reg;
        unique case (state_reg)
            cgs_pkg::ST_CHK_RD, cgs_pkg::ST_ROW_DG:
                mat_re = 1'b1;
            cgs_pkg::ST_ROW_RHS:
            begin
                mat_re    = 1'b1;
                mat_raddr = maddr(i_reg, n_reg);
            end
            cgs_pkg::ST_J_RD:
            begin
                mat_re    = 1'b1;
                mat_raddr = maddr(i_reg, j_reg);
                gs_re     = 1'b1;
                gs_raddr  = j_reg[GW-1:0];
            end
            cgs_pkg::ST_TOL:
            begin
                mul_a = {2'b00, tol_reg};
                mul_b = {2'b00, tol_reg};
            end
            cgs_pkg::ST_J_M0:
            begin
                mul_a = s33(cre);
                mul_b = s33(zre);
                cmd   = '{1'b1, cgs_pkg::TGT_RR, cgs_pkg::SHF_FLOOR, 1'b0};
            end
            cgs_pkg::ST_J_M1:
            begin
                mul_a = s33(cim);
                mul_b = s33(zim);
                cmd   = '{1'b1, cgs_pkg::TGT_RR, cgs_pkg::SHF_FLOOR, 1'b1};
            end
            cgs_pkg::ST_J_M2:
            begin
                mul_a = s33(cre);
                mul_b = s33(zim);
                cmd   = '{1'b1, cgs_pkg::TGT_RI, cgs_pkg::SHF_FLOOR, 1'b0};
            end
            cgs_pkg::ST_J_M3:
            begin
                mul_a = s33(cim);
                mul_b = s33(zre);
                cmd   = '{1'b1, cgs_pkg::TGT_RI, cgs_pkg::SHF_FLOOR, 1'b0};
            end
            cgs_pkg::ST_DEN0:
            begin
                gs_re = 1'b1;
                mul_a = s33(dr_reg);
                mul_b = s33(dr_reg);
                cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
            end
            cgs_pkg::ST_DEN1:
            begin
                mul_a = s33(di_reg);
                mul_b = s33(di_reg);
                cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
            end
            cgs_pkg::ST_LHS:
            begin
                case (k_reg[1:0])
                    2'd0:
                    begin
                        mul_a = lo33(lx);
                        mul_b = lo33(lx);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
                    end
                    2'd1, 2'd2:
                    begin
                        mul_a = shi33(lx);
                        mul_b = lo33(lx);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    default:
                    begin
                        mul_a = shi33(lx);
                        mul_b = shi33(lx);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_64, 1'b0};
                    end
                endcase
            end
            cgs_pkg::ST_RHS:
            begin
                case (k_reg[1:0])
                    2'd0:
                    begin
                        mul_a = lo33(tol2_reg);
                        mul_b = lo33(acc_reg[63:0]);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
                    end
                    2'd1:
                    begin
                        mul_a = lo33(tol2_reg);
                        mul_b = uhi33(den_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    2'd2:
                    begin
                        mul_a = uhi33(tol2_reg);
                        mul_b = lo33(den_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    default:
                    begin
                        mul_a = uhi33(tol2_reg);
                        mul_b = uhi33(den_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_64, 1'b0};
                    end
                endcase
                // den is captured in the first LHS step; first RHS step uses it
                if (k_reg[1:0] == 2'd0)
                    mul_b = lo33(den_reg);
            end
            cgs_pkg::ST_UPD:
            begin
                case ({upd_im_reg, k_reg[1:0]})
                    3'b000:
                    begin
                        mul_a = lo33(rr_reg);
                        mul_b = s33(dr_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
                    end
                    3'b001:
                    begin
                        mul_a = shi33(rr_reg);
                        mul_b = s33(dr_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    3'b010:
                    begin
                        mul_a = lo33(ri_reg);
                        mul_b = s33(di_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
                    end
                    3'b011:
                    begin
                        mul_a = shi33(ri_reg);
                        mul_b = s33(di_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    3'b100:
                    begin
                        mul_a = lo33(ri_reg);
                        mul_b = s33(dr_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b0};
                    end
                    3'b101:
                    begin
                        mul_a = shi33(ri_reg);
                        mul_b = s33(dr_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b0};
                    end
                    3'b110:
                    begin
                        mul_a = lo33(rr_reg);
                        mul_b = s33(di_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_0, 1'b1};
                    end
                    default:
                    begin
                        mul_a = shi33(rr_reg);
                        mul_b = s33(di_reg);
                        cmd   = '{1'b1, cgs_pkg::TGT_ACC, cgs_pkg::SHF_32, 1'b1};
                    end
                endcase
            end
            cgs_pkg::ST_OUT_RD:
                gs_re = 1'b1;
            default: ;
        endcase
    end

    // ---------------- shared multiply-accumulate ----------------
    assign prod_next = mul_a * mul_b;
    assign fl        = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        case (cmd_reg.shf)
            cgs_pkg::SHF_FLOOR: addend = {{62{fl[65]}}, fl};
            cgs_pkg::SHF_0:     addend = {{62{prod_reg[65]}}, prod_reg};
            cgs_pkg::SHF_32:    addend = {{62{prod_reg[65]}}, prod_reg} << 32;
            default:            addend = {{62{prod_reg[65]}}, prod_reg} << 64;
        endcase
        case (cmd_reg.tgt)
            cgs_pkg::TGT_RR: base = {{64{rr_reg[63]}}, rr_reg};
            cgs_pkg::TGT_RI: base = {{64{ri_reg[63]}}, ri_reg};
            default:         base = acc_reg;
        endcase
        sum = cmd_reg.sub ? base - addend : base + addend;
    end

    // ---------------- divider and update result ----------------
    assign acc_mag = acc_reg[127] ? (128'd0 - acc_reg) : acc_reg;
    assign rem_sh  = {rem_reg, num_reg[127]};
    assign rem_dif = rem_sh - {1'b0, den_reg};
    assign div_ge  = !rem_dif[64];

    always_comb
    begin
        q_big = sticky_reg || (q_reg[32] && (q_reg[31:0] != '0));
        qm    = q_big ? {1'b1, 32'd0} : q_reg;
        z     = upd_im_reg ? zim : zre;
        zx    = {{3{z[31]}}, z};
        qx    = {2'b00, qm};
        dif   = neg_reg ? zx + qx : zx - qx;
        if (dif[34] && (dif[33:31] != 3'b111))
            sat = 32'h8000_0000;
        else if (!dif[34] && (dif[33:31] != 3'b000))
            sat = 32'h7FFF_FFFF;
        else
            sat = dif[31:0];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cgs_pkg::ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= NW'(1);
            k_reg      <= '0;
            cnt_reg    <= '0;
            upd_im_reg <= 1'b0;
            again_reg  <= 1'b0;
            fail_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            rv_reg     <= 1'b0;
            sweep_reg  <= '0;
            cmd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd;
            rv_reg    <= 1'b0;
            case (state_reg)
                cgs_pkg::ST_IDLE:
                    if (accept && item.kind == cgs_pkg::KIND_SOLVE)
                    begin
                        n_reg     <= n_clamp;
                        i_reg     <= '0;
                        fail_reg  <= 1'b0;
                        sweep_reg <= '0;
                    end
                cgs_pkg::ST_CHK_TST:
                begin
                    if (diag_zero)
                        fail_reg <= 1'b1;
                    if (row_last)
                    begin
                        i_reg     <= '0;
                        again_reg <= 1'b0;
                        ok_reg    <= !(fail_reg || diag_zero);
                    end
                    else
                        i_reg <= NW'(i_reg + 1'b1);
                end
                cgs_pkg::ST_ROW_INIT: j_reg <= '0;
                cgs_pkg::ST_J_M3:     j_reg <= NW'(j_reg + 1'b1);
                cgs_pkg::ST_DEN0:     k_reg <= '0;
                cgs_pkg::ST_LHS, cgs_pkg::ST_RHS, cgs_pkg::ST_UPD:
                    k_reg <= k_reg + 3'd1;
                cgs_pkg::ST_LHS_W, cgs_pkg::ST_RHS_W, cgs_pkg::ST_UPD_W:
                    k_reg <= '0;
                cgs_pkg::ST_CMP:
                    if (lhs_reg >= (acc_reg >> (2 * FRAC_BITS)))
                        again_reg <= 1'b1;
                cgs_pkg::ST_DSET:     cnt_reg <= '0;
                cgs_pkg::ST_DIV:      cnt_reg <= cnt_reg + 7'd1;
                cgs_pkg::ST_DEND:
                    if (!upd_im_reg)
                        upd_im_reg <= 1'b1;
                    else
                    begin
                        upd_im_reg <= 1'b0;
                        if (row_last)
                        begin
                            sweep_reg <= sc_inc;
                            i_reg     <= '0;
                            if (more)
                                again_reg <= 1'b0;
                            else
                                ok_reg <= (sc_inc < {1'b0, maxit_reg});
                        end
                        else
                            i_reg <= NW'(i_reg + 1'b1);
                    end
                cgs_pkg::ST_OUT_EMIT:
                begin
                    rv_reg <= 1'b1;
                    i_reg  <= NW'(i_reg + 1'b1);
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd_reg.en)
        begin
            case (cmd_reg.tgt)
                cgs_pkg::TGT_RR: rr_reg  <= sum[63:0];
                cgs_pkg::TGT_RI: ri_reg  <= sum[63:0];
                default:         acc_reg <= sum;
            endcase
        end
        case (state_reg)
            cgs_pkg::ST_TOL_W:   tol2_reg <= prod_reg[63:0];
            cgs_pkg::ST_ROW_RHS:
            begin
                dr_reg <= cre;
                di_reg <= cim;
            end
            cgs_pkg::ST_ROW_INIT:
            begin
                rr_reg <= 64'd0 - sx64(cre);
                ri_reg <= 64'd0 - sx64(cim);
            end
            cgs_pkg::ST_DEN0:    acc_reg <= '0;
            cgs_pkg::ST_LHS:
                if (k_reg == 3'd0)
                begin
                    den_reg <= acc_reg[63:0];
                    acc_reg <= '0;
                end
            cgs_pkg::ST_RHS:
                if (k_reg == 3'd0)
                begin
                    lhs_reg <= acc_reg;
                    acc_reg <= BIAS;
                end
            cgs_pkg::ST_CMP:     acc_reg <= '0;
            cgs_pkg::ST_DSET:
            begin
                neg_reg    <= acc_reg[127];
                num_reg    <= acc_mag << FRAC_BITS;
                rem_reg    <= '0;
                q_reg      <= '0;
                sticky_reg <= 1'b0;
            end
            cgs_pkg::ST_DIV:
            begin
                rem_reg    <= div_ge ? rem_dif[63:0] : rem_sh[63:0];
                num_reg    <= num_reg << 1;
                q_reg      <= {q_reg[31:0], div_ge};
                sticky_reg <= sticky_reg | q_reg[32];
            end
            cgs_pkg::ST_DEND:
                if (!upd_im_reg)
                begin
                    newre_reg <= sat;
                    acc_reg   <= '0;
                end
            cgs_pkg::ST_OUT_EMIT:
            begin
                result_reg.index     <= 4'(i_reg);
                result_reg.re_result <= ok_reg ? zre : 32'd0;
                result_reg.im_result <= ok_reg ? zim : 32'd0;
                result_reg.converged <= ok_reg;
                result_reg.last      <= row_last;
            end
            default: ;
        endcase
    end

    assign busy         = (state_reg != cgs_pkg::ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.converged |-> result.re_result == '0 && result.im_result == '0)
        else $error("failed solve emitted nonzero item");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.kind == cgs_pkg::KIND_SOLVE |=> busy)
        else $error("solve item did not raise busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mat_we |-> state_reg == cgs_pkg::ST_IDLE)
        else $error("matrix written during solve");

    a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cgs_pkg::ST_DIV && cnt_reg != 7'd127 |=> state_reg == cgs_pkg::ST_DIV)
        else $error("divider left early");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for complex_gauss_seidel_solver_unit. Loads complex systems and
// initial guesses, starts solves under several register settings, and checks
// every solution element against an in-bench fixed-point solver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgs_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int     NPH         = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    in_t         item = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        result_valid;
    out_t        result;
    logic [31:0] prdata;
    logic        pready;

    complex_gauss_seidel_solver_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // solver state mirrored in the bench
    int          a_re [MAX_ORDER][MAX_ORDER+1];
    int          a_im [MAX_ORDER][MAX_ORDER+1];
    int          z_re [MAX_ORDER];
    int          z_im [MAX_ORDER];
    logic [4:0]  cfg_order = 5'd1;
    logic [15:0] cfg_max_iter = 16'd100;
    logic [30:0] cfg_tol = 31'd66;

    in_t    pending_items [$];
    out_t   solution_q [$];
    int     idle_pct = 0;
    bit     failed = 1'b0;
    longint cycles = 0;
    bit     clean = 1'b0;

    function automatic int eff_order();
        if (cfg_order == 0)
            return 1;
        if (cfg_order > MAX_ORDER)
            return MAX_ORDER;
        return int'(cfg_order);
    endfunction

    // z - (x*c + y*e) * 2^F / den, quotient capped at 2^32, saturated
    function automatic int guess_update(int z, longint x, longint c, longint y, longint e,
                                        logic [63:0] den);
        logic signed [127:0] xs, cs, ys, es, s;
        logic [127:0]        m, q;
        longint              qs, res;
        xs = x;
        cs = c;
        ys = y;
        es = e;
        s = xs * cs + ys * es;
        m = (s < 0) ? -s : s;
        q = (m << FRAC_BITS) / {64'd0, den};
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        qs = longint'(q[63:0]);
        if (s < 0)
            qs = -qs;
        res = longint'(z) - qs;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return int'(res);
    endfunction

    function automatic void solve_system();
        int                  n, sweeps;
        bit                  ok, again;
        longint              rr, ri, dr, di, cr, ci, zr, zi;
        logic [63:0]         den, tol2;
        logic signed [127:0] r128, i128;
        logic [127:0]        lhs, rhs;
        int                  nre, nim;
        out_t                o;
        n = eff_order();
        ok = 1'b1;
        sweeps = 0;
        for (int i = 0; i < n; i++)
            if (a_re[i][i] == 0 && a_im[i][i] == 0)
                ok = 1'b0;
        if (ok)
        begin
            tol2 = 64'(cfg_tol) * 64'(cfg_tol);
            do
            begin
                again = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    rr = -longint'(a_re[i][n]);
                    ri = -longint'(a_im[i][n]);
                    dr = a_re[i][i];
                    di = a_im[i][i];
                    for (int j = 0; j < n; j++)
                    begin
                        cr = a_re[i][j];
                        ci = a_im[i][j];
                        zr = z_re[j];
                        zi = z_im[j];
                        rr += ((cr * zr) >>> FRAC_BITS) - ((ci * zi) >>> FRAC_BITS);
                        ri += ((cr * zi) >>> FRAC_BITS) + ((ci * zr) >>> FRAC_BITS);
                    end
                    den = 64'(dr * dr) + 64'(di * di);
                    r128 = rr;
                    i128 = ri;
                    lhs = r128 * r128 + i128 * i128;
                    rhs = ({64'd0, tol2} * {64'd0, den} + 128'hFFFF_FFFF) >> (2 * FRAC_BITS);
                    if (lhs >= rhs)
                        again = 1'b1;
                    nre = guess_update(z_re[i], rr, dr, ri, di, den);
                    nim = guess_update(z_im[i], ri, dr, -rr, di, den);
                    z_re[i] = nre;
                    z_im[i] = nim;
                end
                sweeps++;
            end
            while (again && sweeps <= int'(cfg_max_iter));
            if (sweeps >= int'(cfg_max_iter))
                ok = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            o.index     = 4'(i);
            o.re_result = ok ? z_re[i] : 32'sd0;
            o.im_result = ok ? z_im[i] : 32'sd0;
            o.converged = ok;
            o.last      = (i + 1 == n);
            solution_q.push_back(o);
        end
    endfunction

    function automatic void apply_item(in_t it);
        case (it.kind)
            KIND_MAT:
                if (it.col <= MAX_ORDER)
                begin
                    a_re[it.row][it.col] = it.re_value;
                    a_im[it.row][it.col] = it.im_value;
                end
            KIND_GUESS:
            begin
                z_re[it.row] = it.re_value;
                z_im[it.row] = it.im_value;
            end
            KIND_SOLVE:
                solve_system();
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                apply_item(item);
            if (!(start && busy))
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    item  <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            cycles++;
            if (result_valid)
            begin
                if (solution_q.size() == 0)
                begin
                    $error("unexpected result index %0d", result.index);
                    failed = 1'b1;
                end
                else
                begin
                    want = solution_q.pop_front();
                    if (result.index !== want.index)
                    begin
                        $error("index: expected %0d, got %0d", want.index, result.index);
                        failed = 1'b1;
                    end
                    if (result.re_result !== want.re_result)
                    begin
                        $error("re_result: expected %0d, got %0d",
                               want.re_result, result.re_result);
                        failed = 1'b1;
                    end
                    if (result.im_result !== want.im_result)
                    begin
                        $error("im_result: expected %0d, got %0d",
                               want.im_result, result.im_result);
                        failed = 1'b1;
                    end
                    if (result.converged !== want.converged)
                    begin
                        $error("converged: expected %0d, got %0d",
                               want.converged, result.converged);
                        failed = 1'b1;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        failed = 1'b1;
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic in_t mk(logic [1:0] k, int r, int c, int re, int im);
        in_t it;
        it.kind     = k;
        it.row      = 4'(r);
        it.col      = 5'(c);
        it.re_value = re;
        it.im_value = im;
        return it;
    endfunction

    function automatic int srange(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // diagonally dominant entries keep the sweeps short
    function automatic in_t coef_item(int r, int c, int n);
        int re, im;
        if (r == c)
        begin
            re = int'($urandom_range(65536, 131072));
            if ($urandom_range(1))
                re = -re;
            im = srange(32768);
        end
        else if (c == n)
        begin
            re = srange(1 << 20);
            im = srange(1 << 20);
        end
        else
        begin
            re = srange(4096 / n);
            im = srange(4096 / n);
        end
        return mk(KIND_MAT, r, c, re, im);
    endfunction

    function automatic in_t guess_item(int r);
        return mk(KIND_GUESS, r, 0, srange(1 << 19), srange(1 << 19));
    endfunction

    function automatic in_t solve_item();
        return mk(KIND_SOLVE, $urandom_range(15), $urandom_range(31), $urandom, $urandom);
    endfunction

    function automatic int add_system(int n);
        int cnt, k, r;
        cnt = 0;
        if (!clean)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j <= n; j++)
                begin
                    pending_items.push_back(coef_item(i, j, n));
                    cnt++;
                end
                pending_items.push_back(guess_item(i));
                cnt++;
            end
            clean = 1'b1;
        end
        else
        begin
            k = $urandom_range(1, n + 2);
            for (int m = 0; m < k; m++)
            begin
                r = $urandom_range(n - 1);
                if ($urandom_range(3) == 0)
                    pending_items.push_back(guess_item(r));
                else
                    pending_items.push_back(coef_item(r, $urandom_range(n), n));
                cnt++;
            end
        end
        pending_items.push_back(solve_item());
        return cnt + 1;
    endfunction

    function automatic void add_noise(int n);
        int sel;
        sel = $urandom_range(99);
        clean = 1'b0;
        if (sel < 20)
            pending_items.push_back(mk(2'd3, $urandom_range(15), $urandom_range(31),
                                       $urandom, $urandom));
        else if (sel < 45)
            pending_items.push_back(mk(KIND_MAT, $urandom_range(15), $urandom_range(31),
                                       $urandom, $urandom));
        else if (sel < 60)
        begin
            sel = $urandom_range(n - 1);
            pending_items.push_back(mk(KIND_MAT, sel, sel, 0, 0));
        end
        else
            pending_items.push_back(mk(KIND_GUESS, $urandom_range(15), $urandom_range(31),
                                       $urandom, $urandom));
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORDER:    cfg_order = v[4:0];
            REG_MAX_ITER: cfg_max_iter = v[15:0];
            REG_TOL:      cfg_tol = v[30:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || start || busy || solution_q.size() > 0);
        repeat (10) @(posedge clk);
    endtask

    int ph_order [NPH] = '{0, 3, 5, 2, 16, 31, 4, 1};
    int ph_iter  [NPH] = '{8, 12, 3, 1, 65535, 2, 20, 65535};
    int ph_tol   [NPH] = '{66, 66, 0, 2147483647, 2147483647, 1000, 200, 66};
    bit ph_noise [NPH] = '{1, 1, 1, 1, 0, 1, 1, 0};
    int ph_items [NPH] = '{50, 60, 55, 45, 20, 40, 60, 40};
    int idle_tab [3]   = '{0, 78, 32};

    initial
    begin
        int n, cnt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored items, a clean solve, zero diagonal, extreme values
        write_reg(REG_ORDER, 32'd2);
        write_reg(REG_MAX_ITER, 32'd5);
        write_reg(REG_TOL, 32'd66);
        pending_items.push_back(mk(2'd3, 15, 31, -1, -1));
        pending_items.push_back(mk(KIND_MAT, 15, 31, 32'sh8000_0000, 32'sh7fff_ffff));
        clean = 1'b0;
        void'(add_system(2));
        pending_items.push_back(mk(KIND_MAT, 1, 1, 0, 0));
        pending_items.push_back(solve_item());
        pending_items.push_back(mk(KIND_MAT, 1, 1, 32'sh8000_0000, 0));
        pending_items.push_back(mk(KIND_MAT, 0, 2, 32'sh7fff_ffff, 32'sh8000_0000));
        pending_items.push_back(mk(KIND_MAT, 0, 1, 32'sh7fff_ffff, 32'sh7fff_ffff));
        pending_items.push_back(mk(KIND_GUESS, 1, 0, 32'sh8000_0000, 32'sh7fff_ffff));
        pending_items.push_back(solve_item());
        pending_items.push_back(mk(KIND_GUESS, 15, 16, 0, 0));
        pending_items.push_back(mk(KIND_MAT, 1, 2, 0, -1));
        pending_items.push_back(solve_item());
        wait_idle();

        for (int p = 0; p < NPH; p++)
        begin
            write_reg(REG_ORDER, 32'(ph_order[p]));
            write_reg(REG_MAX_ITER, 32'(ph_iter[p]));
            write_reg(REG_TOL, 32'(ph_tol[p]));
            idle_pct = idle_tab[p % 3];
            n = eff_order();
            clean = 1'b0;
            cnt = 0;
            while (cnt < ph_items[p])
            begin
                if (ph_noise[p] && clean && $urandom_range(99) < 20)
                begin
                    add_noise(n);
                    cnt++;
                end
                else
                    cnt += add_system(n);
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (!failed)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cgs_pkg.sv
rtl/complex_gauss_seidel_solver_unit.sv
dv/tb.sv
